### src/ppm_bit_slicer_assert.svh
// assertion helpers shared by the slicer modules
`ifndef PPM_BIT_SLICER_ASSERT_SVH
`define PPM_BIT_SLICER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define PPMS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// antecedent in a cycle implies consequent in the next
`define PPMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/ppms_pkg.sv
`default_nettype none

package ppms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 7;
    localparam int STAMP_BITS  = 48;

    localparam logic [COUNT_BITS-1:0] LONG_BITS   = 7'd112;
    localparam logic [COUNT_BITS-1:0] SHORT_BITS  = 7'd56;
    localparam logic [COUNT_BITS-1:0] SPB_RESET   = 7'd8;
    localparam logic [COUNT_BITS-1:0] WEAK_ENERGY = 7'd6;

    // gains in 16-bit fraction: +3 dB, -3 dB, -6 dB
    localparam logic [16:0] GAIN_UP   = 17'd92572;
    localparam logic [15:0] GAIN_DOWN = 16'd46396;
    localparam logic [15:0] GAIN_WEAK = 16'd32847;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic {
        KIND_BIT = 1'b0,
        KIND_END = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CONF_HIGH = 2'd0,
        CONF_LOW  = 2'd1,
        CONF_WEAK = 2'd2
    } conf_t;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_SHORT = 2'd1,
        CLASS_LONG  = 2'd2
    } class_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mag;
        logic                   start;
        logic                   lead_edge;
        logic                   end_mark;
        logic [SAMPLE_BITS-1:0] ref_lvl;
        logic [SAMPLE_BITS:0]   upper;
        logic [SAMPLE_BITS-1:0] lower;
        logic [SAMPLE_BITS-1:0] low_lim;
    } sample_t;

    typedef struct packed {
        kind_t                  kind;
        logic [COUNT_BITS-1:0]  pos;
        logic                   value;
        conf_t                  conf;
        class_t                 cls;
        logic [STAMP_BITS-1:0]  stamp;
        logic [SAMPLE_BITS-1:0] ref_lvl;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

### src/ppm_bit_slicer.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: magnitude, ref_level
//                                               tuser: data start, leading edge
//                                               tlast: data end
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: bit fields, stamp, reference
//                                               tuser: result kind, tlast: last
// cfg       in   cfg_valid/cfg_ready            cfg_data: samples_per_bit
//
// one sample per cycle while the queue has room; a sample goes input register ->
// slicer logic -> 4-entry result queue, so its first result is valid once the
// input register has taken it and the queue has written it
// the input side stalls while the queue has fewer than two free entries; a
// sample that decides a bit and closes the frame gives two results, which
// drain at one per cycle on the output side while m_axis_tready is high
// reset (rst_n low, asynchronous) clears frame state, the sample counter and
// the queue, and sets samples_per_bit to 8; no clearing pass is needed
`default_nettype none

module ppm_bit_slicer
    import ppms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // magnitude[15:0], ref_level[31:16]
    input  wire logic [1:0]  s_axis_tuser,  // is_data_start[0], is_leading_edge[1]
    input  wire logic        s_axis_tlast,  // is_data_end
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // bit_position[6:0], bit_value[7],
                                            // confidence[9:8], frame_class[11:10],
                                            // start_stamp[59:12],
                                            // frame_reference[75:60], zero[79:76]
    output logic             m_axis_tuser,  // result_kind
    output logic             m_axis_tlast,  // last
    // samples_per_bit write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data
);

    logic                    in_valid_reg, in_valid_next;
    sample_t                 in_item_reg, in_item_next;
    logic [COUNT_BITS-1:0]   spb_reg, spb_next;
    logic                    advance, accept;
    logic                    room2;
    logic [SAMPLE_BITS-1:0]  ref_in;
    logic [2*SAMPLE_BITS:0]  prod_up;
    logic [2*SAMPLE_BITS-1:0] prod_down, prod_weak;
    push_t                   push;
    result_t                 head;

    // the limit products are formed ahead of the input register so the
    // slicer stage only compares
    assign ref_in    = s_axis_tdata[31:16];
    assign prod_up   = (2*SAMPLE_BITS+1)'(ref_in) * (2*SAMPLE_BITS+1)'(GAIN_UP);
    assign prod_down = (2*SAMPLE_BITS)'(ref_in) * (2*SAMPLE_BITS)'(GAIN_DOWN);
    assign prod_weak = (2*SAMPLE_BITS)'(ref_in) * (2*SAMPLE_BITS)'(GAIN_WEAK);

    // the held sample moves on when the queue can take two results
    assign advance       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        spb_next      = spb_reg;
        if (advance)
            in_valid_next = 1'b0;
        if (accept)
        begin
            in_valid_next          = 1'b1;
            in_item_next.mag       = s_axis_tdata[15:0];
            in_item_next.start     = s_axis_tuser[0];
            in_item_next.lead_edge = s_axis_tuser[1];
            in_item_next.end_mark  = s_axis_tlast;
            in_item_next.ref_lvl   = ref_in;
            in_item_next.upper     = prod_up[2*SAMPLE_BITS:SAMPLE_BITS];
            in_item_next.lower     = prod_down[2*SAMPLE_BITS-1:SAMPLE_BITS];
            in_item_next.low_lim   = prod_weak[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (cfg_valid)
            spb_next = cfg_data;
    end

    // sample payload, no reset
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            spb_reg      <= SPB_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            spb_reg      <= spb_next;
        end
    end

    ppms_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .item            (in_item_reg),
        .samples_per_bit (spb_reg),
        .push            (push)
    );

    ppms_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room2      (room2),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready),
        .head       (head)
    );

    assign m_axis_tdata = {4'b0000, head.ref_lvl, head.stamp, head.cls, head.conf,
                           head.value, head.pos};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

### src/ppms_core.sv
`default_nettype none
`include "ppm_bit_slicer_assert.svh"

module ppms_core
    import ppms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire sample_t               item,
    input  wire logic [COUNT_BITS-1:0] samples_per_bit,
    output push_t                      push
);

    logic                   in_frame_reg, in_frame_next;
    logic                   end_pending_reg, end_pending_next;
    logic [COUNT_BITS-1:0]  phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  f_ok_reg, f_ok_next, f_weak_reg, f_weak_next;
    logic [COUNT_BITS-1:0]  s_ok_reg, s_ok_next, s_weak_reg, s_weak_next;
    logic [COUNT_BITS-1:0]  bits_done_reg, bits_done_next;
    logic [SAMPLE_BITS:0]   upper_reg, upper_next;
    logic [SAMPLE_BITS-1:0] lower_reg, lower_next;
    logic [SAMPLE_BITS-1:0] weak_reg, weak_next;
    logic [SAMPLE_BITS-1:0] held_ref_reg, held_ref_next;
    logic [STAMP_BITS-1:0]  counter_reg, counter_next;
    logic [STAMP_BITS-1:0]  stamp_reg, stamp_next;

    logic [COUNT_BITS-2:0]  chip;
    logic [COUNT_BITS-1:0]  chip_p1;
    logic [COUNT_BITS:0]    ph_p1;
    logic [1:0]             w;
    logic                   ok, weak_hit, decide, close;
    logic signed [COUNT_BITS+1:0] d;
    logic [COUNT_BITS+1:0]  mag_d;
    result_t                bit_res, end_res;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [1:0]            b
    );
        logic [COUNT_BITS:0] s;
        begin
            s = {1'b0, a} + {{(COUNT_BITS-1){1'b0}}, b};
            sat_add = s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
        end
    endfunction

    assign chip    = samples_per_bit[COUNT_BITS-1:1];
    assign chip_p1 = {1'b0, chip} + 7'd1;

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        end_pending_next = end_pending_reg;
        phase_next       = phase_reg;
        f_ok_next        = f_ok_reg;
        f_weak_next      = f_weak_reg;
        s_ok_next        = s_ok_reg;
        s_weak_next      = s_weak_reg;
        bits_done_next   = bits_done_reg;
        upper_next       = upper_reg;
        lower_next       = lower_reg;
        weak_next        = weak_reg;
        held_ref_next    = held_ref_reg;
        counter_next     = counter_reg;
        stamp_next       = stamp_reg;
        ph_p1            = '0;
        w                = 2'd1;
        ok               = 1'b0;
        weak_hit         = 1'b0;
        decide           = 1'b0;
        close            = 1'b0;
        d                = '0;
        mag_d            = '0;
        bit_res          = '0;
        end_res          = '0;
        push             = '0;

        if (step)
        begin
            counter_next = counter_reg + 48'd1;

            // frame open
            if (!in_frame_reg && item.start)
            begin
                held_ref_next    = item.ref_lvl;
                upper_next       = item.upper;
                lower_next       = item.lower;
                weak_next        = item.low_lim;
                stamp_next       = counter_reg;
                in_frame_next    = 1'b1;
                phase_next       = '0;
                end_pending_next = 1'b0;
                bits_done_next   = '0;
                f_ok_next        = '0;
                f_weak_next      = '0;
                s_ok_next        = '0;
                s_weak_next      = '0;
            end

            if (in_frame_next)
            begin
                // phase resync, checks chained in order
                if (item.lead_edge)
                begin
                    if (phase_next == 7'd1)
                    begin
                        phase_next  = '0;
                        f_ok_next   = '0;
                        f_weak_next = '0;
                    end
                    if (phase_next == 7'd3)
                        phase_next = 7'd4;
                    if (phase_next == chip_p1)
                    begin
                        phase_next  = {1'b0, chip};
                        s_ok_next   = '0;
                        s_weak_next = '0;
                    end
                    if (phase_next == 7'd7)
                        phase_next = 7'd8;
                end

                // edge samples of a chip weigh one
                ph_p1 = {1'b0, phase_next} + 8'd1;
                if (phase_next == '0 || ph_p1 == {2'b00, chip} ||
                    phase_next == {1'b0, chip} || ph_p1 >= {1'b0, samples_per_bit})
                    w = 2'd1;
                else
                    w = 2'd2;

                ok       = item.mag >= lower_next && {1'b0, item.mag} <= upper_next;
                weak_hit = !ok && item.mag < weak_next;

                if (phase_next < {1'b0, chip})
                begin
                    if (ok)
                        f_ok_next = sat_add(f_ok_next, w);
                    else if (weak_hit)
                        f_weak_next = sat_add(f_weak_next, w);
                end
                else if (phase_next < samples_per_bit)
                begin
                    if (ok)
                        s_ok_next = sat_add(s_ok_next, w);
                    else if (weak_hit)
                        s_weak_next = sat_add(s_weak_next, w);
                end

                phase_next = sat_add(phase_next, 2'd1);
                decide     = phase_next >= samples_per_bit;

                if (decide)
                begin
                    d = $signed({2'b00, f_ok_next}) + $signed({2'b00, s_weak_next})
                      - $signed({2'b00, f_weak_next}) - $signed({2'b00, s_ok_next});
                    mag_d = d[COUNT_BITS+1] ? -d : d;
                    bit_res.kind    = KIND_BIT;
                    bit_res.pos     = bits_done_next;
                    bit_res.stamp   = stamp_next;
                    bit_res.ref_lvl = held_ref_next;
                    if (mag_d >= 9'd2)
                    begin
                        bit_res.conf  = CONF_HIGH;
                        bit_res.value = !d[COUNT_BITS+1];
                    end
                    else if (mag_d == 9'd1)
                    begin
                        bit_res.conf  = CONF_LOW;
                        bit_res.value = !d[COUNT_BITS+1];
                    end
                    else if (s_weak_next >= WEAK_ENERGY)
                        bit_res.conf = CONF_WEAK;
                    else
                        bit_res.conf = CONF_LOW;

                    bits_done_next = sat_add(bits_done_next, 2'd1);
                    phase_next     = '0;
                    f_ok_next      = '0;
                    f_weak_next    = '0;
                    s_ok_next      = '0;
                    s_weak_next    = '0;
                    close = end_pending_next || bits_done_next >= LONG_BITS;
                end

                if (!close && item.end_mark)
                begin
                    if (phase_next == '0)
                        close = 1'b1;
                    else
                        end_pending_next = 1'b1;
                end

                if (close)
                begin
                    end_res.kind    = KIND_END;
                    end_res.pos     = bits_done_next;
                    end_res.stamp   = stamp_next;
                    end_res.ref_lvl = held_ref_next;
                    end_res.last    = 1'b1;
                    if (bits_done_next >= LONG_BITS)
                        end_res.cls = CLASS_LONG;
                    else if (bits_done_next >= SHORT_BITS)
                        end_res.cls = CLASS_SHORT;
                    else
                        end_res.cls = CLASS_NONE;
                    in_frame_next    = 1'b0;
                    end_pending_next = 1'b0;
                    phase_next       = '0;
                    f_ok_next        = '0;
                    f_weak_next      = '0;
                    s_ok_next        = '0;
                    s_weak_next      = '0;
                end

                // pack results in order, first slot first
                if (decide)
                begin
                    bit_res.last = !close;
                    push.res0    = bit_res;
                    push.res1    = end_res;
                    push.n       = close ? 2'd2 : 2'd1;
                end
                else if (close)
                begin
                    push.res0 = end_res;
                    push.n    = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            end_pending_reg <= 1'b0;
            phase_reg       <= '0;
            f_ok_reg        <= '0;
            f_weak_reg      <= '0;
            s_ok_reg        <= '0;
            s_weak_reg      <= '0;
            bits_done_reg   <= '0;
            upper_reg       <= '0;
            lower_reg       <= '0;
            weak_reg        <= '0;
            held_ref_reg    <= '0;
            counter_reg     <= '0;
            stamp_reg       <= '0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            end_pending_reg <= end_pending_next;
            phase_reg       <= phase_next;
            f_ok_reg        <= f_ok_next;
            f_weak_reg      <= f_weak_next;
            s_ok_reg        <= s_ok_next;
            s_weak_reg      <= s_weak_next;
            bits_done_reg   <= bits_done_next;
            upper_reg       <= upper_next;
            lower_reg       <= lower_next;
            weak_reg        <= weak_next;
            held_ref_reg    <= held_ref_next;
            counter_reg     <= counter_next;
            stamp_reg       <= stamp_next;
        end
    end

    `PPMS_ASSERT_ALWAYS(a_idle_phase, in_frame_reg || phase_reg == '0)
    `PPMS_ASSERT_ALWAYS(a_idle_no_pending, in_frame_reg || !end_pending_reg)
    `PPMS_ASSERT_ALWAYS(a_bits_bounded, bits_done_reg <= LONG_BITS)

endmodule

`default_nettype wire

### src/ppms_fifo.sv
`default_nettype none
`include "ppm_bit_slicer_assert.svh"

module ppms_fifo
    import ppms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room2,
    output logic       head_valid,
    input  wire logic  head_ready,
    output result_t    head
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [FIFO_AW-1:0]   wr_ptr_p1;
    logic                 pop;

    assign wr_ptr_p1  = wr_ptr_reg + FIFO_AW'(1);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    assign room2      = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.n);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_ptr_reg] <= push.res0;
        if (push.n == 2'd2)
            mem[wr_ptr_p1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PPMS_ASSERT_ALWAYS(a_count_bounded, count_reg <= FIFO_CW'(FIFO_DEPTH))
    `PPMS_ASSERT_ALWAYS(a_push_fits, {1'b0, count_reg} + {2'b00, push.n} <= FIFO_DEPTH)
    `PPMS_ASSERT_NEXT(a_pop_only, pop && push.n == 2'd0, count_reg == $past(count_reg) - 3'd1)

endmodule

`default_nettype wire
